>>> rtl/pcc_pkg.sv
// shared widths, register indexes and constants of the clamped pid controller
`default_nettype none
package pcc_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned DerivW = 18;
  localparam int unsigned AccW   = 48;
  localparam int unsigned SumW   = 64;
  localparam int unsigned MulAW  = 32;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned FracW  = 24;
  localparam int unsigned RndW   = SumW - FracW;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegKp     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKi     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKd     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDt     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutMin = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOutMax = 3'd5;

  localparam logic signed [DataW-1:0] OutMinReset = 16'sh8000;
  localparam logic signed [DataW-1:0] OutMaxReset = 16'sh7fff;

  // half an lsb of the q.24 sum, for round to nearest with ties upward
  localparam logic signed [SumW-1:0] HalfQ24 = 64'sh0000_0000_0080_0000;

  localparam logic signed [AccW-1:0] AccMax = 48'sh7fff_ffff_ffff;
  localparam logic signed [AccW-1:0] AccMin = 48'sh8000_0000_0000;

endpackage
`default_nettype wire

>>> rtl/pid_controller_clamped_top.sv
// pid controller with saturating integral and clamped output on one shared multiplier
// the steps run in order, with at most one multiply per step; a new item is taken only
//   when the last has finished its five products through the single 32x18 multiplier,
//   its integral update and its round/clamp steps
// input is stalled while an item is in work; a finished result waits in the output register
// reset: asynchronous, clears integral and last error, gains and dt to 0, clamp to full range
`default_nettype none
module pid_controller_clamped_top
  import pcc_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [DataW-1:0]          cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [DataW-1:0]   measured_i,
  input  wire logic signed [DataW-1:0]   target_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [DataW-1:0]        drive_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMdt  = 3'd1;
  localparam logic [2:0] StInt  = 3'd2;
  localparam logic [2:0] StP    = 3'd3;
  localparam logic [2:0] StD    = 3'd4;
  localparam logic [2:0] StIlo  = 3'd5;
  localparam logic [2:0] StIhi  = 3'd6;
  localparam logic [2:0] StRnd  = 3'd7;

  logic [2:0] state_q, state_d;

  logic signed [DataW-1:0] kp_q, ki_q, kd_q, out_min_q, out_max_q;
  logic        [DataW-1:0] dt_q;

  logic signed [ErrW-1:0]  err_q, last_err_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [DataW-1:0] drive_q;
  logic                    out_valid_q;

  logic signed [MulAW-1:0] op_a;
  logic signed [MulBW-1:0] op_b;
  logic signed [DerivW-1:0] deriv;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW-1:0]  acc_sat;
  logic signed [SumW-1:0]  prod_ext;
  logic signed [SumW-1:0]  prod_shl;
  logic signed [RndW-1:0]  rnd;
  logic signed [DataW-1:0] clamped;
  logic                    in_xfer;
  logic                    out_free;

  assign in_xfer  = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  assign deriv = DerivW'(err_q) - DerivW'(last_err_q);

  // operand select of the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      StMdt: begin
        op_a = MulAW'(err_q);
        op_b = signed'({2'b00, dt_q});
      end
      StInt: begin
        op_a = MulAW'(err_q);
        op_b = MulBW'(kp_q);
      end
      StP: begin
        op_a = MulAW'(deriv);
        op_b = MulBW'(kd_q);
      end
      StD: begin
        op_a = signed'({16'b0, acc_q[15:0]});
        op_b = MulBW'(ki_q);
      end
      StIlo: begin
        op_a = acc_q[AccW-1:16];
        op_b = MulBW'(ki_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  assign acc_sum = (AccW+1)'(acc_q) + (AccW+1)'(prod_q);
  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? AccMin : AccMax;
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  assign prod_ext = SumW'(prod_q);
  assign prod_shl = prod_ext <<< 16;

  // sum already holds the rounding half, so the integer part is a plain select
  assign rnd = sum_q[SumW-1:FracW];
  always_comb begin
    if (rnd > RndW'(out_max_q)) begin
      clamped = out_max_q;
    end else if (rnd < RndW'(out_min_q)) begin
      clamped = out_min_q;
    end else begin
      clamped = rnd[DataW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_xfer) state_d = StMdt;
      StMdt:  state_d = StInt;
      StInt:  state_d = StP;
      StP:    state_d = StD;
      StD:    state_d = StIlo;
      StIlo:  state_d = StIhi;
      StIhi:  state_d = StRnd;
      StRnd:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      last_err_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StInt) begin
        acc_q <= acc_sat;
      end
      if (state_q == StRnd && out_free) begin
        out_valid_q <= 1'b1;
        last_err_q  <= err_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      dt_q      <= '0;
      out_min_q <= OutMinReset;
      out_max_q <= OutMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKp:     kp_q      <= signed'(cfg_data_i);
        RegKi:     ki_q      <= signed'(cfg_data_i);
        RegKd:     kd_q      <= signed'(cfg_data_i);
        RegDt:     dt_q      <= cfg_data_i;
        RegOutMin: out_min_q <= signed'(cfg_data_i);
        RegOutMax: out_max_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_xfer) begin
      err_q <= ErrW'(target_i) - ErrW'(measured_i);
      sum_q <= HalfQ24;
    end
    unique case (state_q) inside
      StP, StD, StIhi: sum_q <= sum_q + prod_shl;
      StIlo:           sum_q <= sum_q + prod_ext;
      default: ;
    endcase
    if (state_q == StRnd && out_free) begin
      drive_q <= clamped;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule
`default_nettype wire
